### rtl/ilbp_pkg.sv
// ============================================================================
// ilbp_pkg: shared types and constants of the integer list parser
// Character codes, phase and status encodings, and the result struct.
// ============================================================================
`default_nettype none

package ilbp_pkg;

  // Character codes
  localparam logic [7:0] CH_EOL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_COMMA = 8'd44;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_EOF   = 8'd255;

  // Widths of the result payload
  localparam int unsigned SET_BITS_MAX = 128;
  localparam int unsigned HALF_W       = 64;
  localparam int unsigned STATUS_W     = 3;
  localparam int unsigned OUT_DATA_W   = 136;

  // Parse phase, one-hot
  typedef enum logic [4:0] {
    PH_START  = 5'b00001,
    PH_MINUS  = 5'b00010,
    PH_NUMBER = 5'b00100,
    PH_AFTER  = 5'b01000,
    PH_TAIL   = 5'b10000
  } phase_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_EARLY_END    = 3'd1,
    ST_EXTRA_COMMA  = 3'd2,
    ST_BAD_MEMBER   = 3'd3,
    ST_FLOAT        = 3'd4,
    ST_MISSED_COMMA = 3'd5,
    ST_GARBAGE      = 3'd6,
    ST_EOF          = 3'd7
  } status_t;

  // Result of one parse step
  typedef struct packed {
    logic    emit;
    status_t status;
  } step_res_t;

endpackage

`default_nettype wire

### rtl/ilbp_step.sv
// ============================================================================
// ilbp_step: one character step of the integer list parser
// Combinational next-state logic for phase, accumulator, sign and bitmap,
// plus the result status and the set reported with it.
// ============================================================================
`default_nettype none

module ilbp_step
  import ilbp_pkg::*;
#(
  parameter int unsigned SET_SIZE = 128
) (
  input  wire logic [7:0]              char_code,
  input  wire phase_t                  phase,
  input  wire logic [7:0]              number_value,
  input  wire logic                    number_negative,
  input  wire logic [SET_SIZE-1:0]     member_bitmap,
  output phase_t                       phase_nxt,
  output logic [7:0]                   number_value_nxt,
  output logic                         number_negative_nxt,
  output logic [SET_SIZE-1:0]          member_bitmap_nxt,
  output step_res_t                    res,
  output logic [SET_BITS_MAX-1:0]      set_data
);

  logic                 is_digit;
  logic                 is_space;
  logic [3:0]           digit;
  logic [11:0]          acc_wide;
  logic [7:0]           acc_sat;
  logic                 set_bit;
  phase_t               eff_phase;
  logic                 handled;
  logic [SET_BITS_MAX-1:0] bitmap_ext;

  // Classify the character
  assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign is_space = (char_code == CH_SPACE) ||
                    ((char_code >= CH_TAB) && (char_code <= CH_CR));
  assign digit    = 4'(char_code - CH_ZERO);

  // Accumulate one decimal digit, saturating at 255
  assign acc_wide = {1'b0, number_value, 3'b000} + {3'b000, number_value, 1'b0} +
                    {8'd0, digit};
  assign acc_sat  = (acc_wide > 12'd255) ? 8'hFF : acc_wide[7:0];

  // Phase update and result decision
  always_comb begin
    phase_nxt           = phase;
    number_value_nxt    = number_value;
    number_negative_nxt = number_negative;
    set_bit             = 1'b0;
    res.emit            = 1'b0;
    res.status          = ST_OK;
    eff_phase           = phase;
    handled             = 1'b0;

    // Inside a number: digits accumulate, anything else ends the number
    if (phase == PH_NUMBER) begin
      if (is_digit) begin
        number_value_nxt = acc_sat;
        handled          = 1'b1;
      end else if (number_negative && (number_value == 8'd1)) begin
        eff_phase = PH_TAIL;
      end else if (char_code == CH_DOT) begin
        res.emit   = 1'b1;
        res.status = ST_FLOAT;
        handled    = 1'b1;
      end else begin
        eff_phase = PH_AFTER;
      end
    end

    // Handle the character in its effective phase
    if (!handled) begin
      phase_nxt = eff_phase;
      unique case (eff_phase)
        PH_MINUS: begin
          if (!is_digit) begin
            res.emit   = 1'b1;
            res.status = ST_BAD_MEMBER;
          end else begin
            number_value_nxt = {4'd0, digit};
            phase_nxt        = PH_NUMBER;
          end
        end
        PH_AFTER: begin
          if (is_space) begin
            phase_nxt = PH_AFTER;
          end else if (char_code == CH_EOL) begin
            res.emit   = 1'b1;
            res.status = ST_EARLY_END;
          end else if (char_code != CH_COMMA) begin
            res.emit   = 1'b1;
            res.status = ST_MISSED_COMMA;
          end else if ((number_negative && (number_value != 8'd0)) ||
                       (number_value >= 8'(SET_SIZE))) begin
            res.emit   = 1'b1;
            res.status = ST_BAD_MEMBER;
          end else begin
            set_bit             = 1'b1;
            phase_nxt           = PH_START;
            number_value_nxt    = 8'd0;
            number_negative_nxt = 1'b0;
          end
        end
        PH_TAIL: begin
          if (is_space) begin
            phase_nxt = PH_TAIL;
          end else if (char_code == CH_EOL) begin
            res.emit   = 1'b1;
            res.status = ST_OK;
          end else begin
            res.emit   = 1'b1;
            res.status = ST_GARBAGE;
          end
        end
        default: begin
          phase_nxt = PH_START;
          if (is_space) begin
            phase_nxt = PH_START;
          end else if (char_code == CH_EOL) begin
            res.emit   = 1'b1;
            res.status = ST_EARLY_END;
          end else if (char_code == CH_EOF) begin
            res.emit   = 1'b1;
            res.status = ST_EOF;
          end else if (char_code == CH_COMMA) begin
            res.emit   = 1'b1;
            res.status = ST_EXTRA_COMMA;
          end else if (char_code == CH_MINUS) begin
            number_negative_nxt = 1'b1;
            number_value_nxt    = 8'd0;
            phase_nxt           = PH_MINUS;
          end else if (!is_digit) begin
            res.emit   = 1'b1;
            res.status = ST_BAD_MEMBER;
          end else begin
            number_negative_nxt = 1'b0;
            number_value_nxt    = {4'd0, digit};
            phase_nxt           = PH_NUMBER;
          end
        end
      endcase
    end

    // Any result returns the parser to its reset state
    if (res.emit) begin
      phase_nxt           = PH_START;
      number_value_nxt    = 8'd0;
      number_negative_nxt = 1'b0;
    end
  end

  // Set the member bit, clear the map after a result
  always_comb begin
    for (int i = 0; i < SET_SIZE; i++) begin
      member_bitmap_nxt[i] = !res.emit &&
                             (member_bitmap[i] || (set_bit && (number_value == 8'(i))));
    end
  end

  // Report the map only on success
  always_comb begin
    bitmap_ext                = '0;
    bitmap_ext[SET_SIZE-1:0]  = member_bitmap;
    set_data                  = (res.status == ST_OK) ? bitmap_ext : '0;
  end

endmodule

`default_nettype wire

### rtl/ilbp_out_reg.sv
// ============================================================================
// ilbp_out_reg: result register of the integer list parser
// Holds one result transaction until the downstream side takes it.
// ============================================================================
`default_nettype none

module ilbp_out_reg
  import ilbp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  load,
  input  wire logic [OUT_DATA_W-1:0] load_data,
  output logic                       can_load,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  logic                  valid_r;
  logic                  valid_nxt;
  logic [OUT_DATA_W-1:0] data_r;

  // Free when empty or being drained this cycle
  assign can_load   = !valid_r || out_tready;
  assign valid_nxt  = load || (valid_r && !out_tready);
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

  // Hold valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

`default_nettype wire

### rtl/int_list_to_bitset_parser_core.sv
// ============================================================================
// int_list_to_bitset_parser_core: comma-separated integer list to bitset
// Parses decimal members ended by -1 into a membership bitmap, one
// character per transaction, and reports status and set per line.
// ============================================================================
//
//  channel | dir | tdata                                   | one per
//  --------+-----+-----------------------------------------+-------------
//  in_     | in  | [7:0] char_code                         | character
//  out_    | out | [2:0] status, [66:3] set_low,           | finished line
//          |     | [130:67] set_high, [135:131] zero       |
//
//  One character per cycle while the result register can take a result: an
//  input register feeds the step logic, which updates the parse state and
//  loads the result register. out_tvalid rises once the last character of a
//  line has gone through the input register and the result register.
//  Reset (rst_n low, synchronous) empties both registers and returns the
//  parser to the start of a line with an empty set.
//  A full result register that is not taken stalls the step at once; the
//  input side stalls while the input register holds a stalled character.
// ============================================================================
`default_nettype none

module int_list_to_bitset_parser_core
  import ilbp_pkg::*;
#(
  parameter int unsigned SET_SIZE = 128
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,   // [7:0] char_code
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata   // [2:0] status, [66:3] set_low,
                                                 // [130:67] set_high
);

  logic                  char_valid_r;
  logic                  char_valid_nxt;
  logic [7:0]            char_r;
  phase_t                phase_r;
  phase_t                phase_nxt;
  logic [7:0]            value_r;
  logic [7:0]            value_nxt;
  logic                  negative_r;
  logic                  negative_nxt;
  logic [SET_SIZE-1:0]   bitmap_r;
  logic [SET_SIZE-1:0]   bitmap_nxt;
  step_res_t             res;
  logic [SET_BITS_MAX-1:0] set_data;
  logic                  can_load;
  logic                  step_go;
  logic [OUT_DATA_W-1:0] result_data;

  // Step when a character is held and the result register can take a result
  assign step_go        = char_valid_r && can_load;
  assign in_tready      = !char_valid_r || step_go;
  assign char_valid_nxt = (in_tvalid && in_tready) || (char_valid_r && !step_go);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_valid_r <= 1'b0;
    end else begin
      char_valid_r <= char_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      char_r <= in_tdata;
    end
  end

  ilbp_step #(
    .SET_SIZE (SET_SIZE)
  ) u_step (
    .char_code           (char_r),
    .phase               (phase_r),
    .number_value        (value_r),
    .number_negative     (negative_r),
    .member_bitmap       (bitmap_r),
    .phase_nxt           (phase_nxt),
    .number_value_nxt    (value_nxt),
    .number_negative_nxt (negative_nxt),
    .member_bitmap_nxt   (bitmap_nxt),
    .res                 (res),
    .set_data            (set_data)
  );

  // Parse state, advanced once per step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_START;
      value_r    <= 8'd0;
      negative_r <= 1'b0;
      bitmap_r   <= '0;
    end else if (step_go) begin
      phase_r    <= phase_nxt;
      value_r    <= value_nxt;
      negative_r <= negative_nxt;
      bitmap_r   <= bitmap_nxt;
    end
  end

  // Pack the result transaction
  assign result_data = {5'd0, set_data[SET_BITS_MAX-1:HALF_W], set_data[HALF_W-1:0],
                        res.status};

  ilbp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step_go && res.emit),
    .load_data  (result_data),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef NO_ASSERTIONS
  // Phase register stays one-hot
  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(phase_r))
    else $error("parse phase not one-hot");

  // A result leaves an empty set behind
  a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (step_go && res.emit) |=> (bitmap_r == '0) && (phase_r == PH_START))
    else $error("state not cleared after result");

  // A failed line reports an empty set
  a_error_empty_set: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[STATUS_W-1:0] != ST_OK)) |->
      (out_tdata[OUT_DATA_W-1:STATUS_W] == '0))
    else $error("nonzero set with error status");

  // The minus phase only follows a sign
  a_minus_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_MINUS) |-> (negative_r && (value_r == 8'd0)))
    else $error("minus phase without sign");
`endif

endmodule

`default_nettype wire
